@@ sv/spike_range_leaky_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the spike range leaky decoder
// Shared concurrent checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SPIKE_RANGE_LEAKY_DECODER_TOP_MACROS_SVH
`define SPIKE_RANGE_LEAKY_DECODER_TOP_MACROS_SVH

// expression must hold at every clock edge out of reset
`define SRLD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SRLD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/srld_pkg.sv @@
// ----------------------------------------------------------------------------
// srld_pkg
// Types, field widths and helpers shared by the decoder front, back and queue.
// ----------------------------------------------------------------------------
package srld_pkg;

  // field widths of the stream words
  localparam int IDX_W    = 16;
  localparam int CH_W     = 2;
  localparam int STEP_W   = 24;
  localparam int VAL_W    = 32;
  localparam int DECAY_W  = 17;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 64;
  localparam int PROD_W   = 50;  // 32 signed x 18 signed
  localparam int TRUNC_W  = 34;  // product after dropping 16 fraction bits
  localparam int SUM_W    = 35;  // headroom for add before saturation

  localparam logic [DECAY_W-1:0] DECAY_RESET = 17'd65536;
  localparam logic               SIDE_AGONIST = 1'b0;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = 3;
  localparam int OUTQ_PTR_W = 2;

  typedef enum logic [1:0] {
    ACT_SPIKE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_SPIKE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_ISSUE = 1'b1
  } back_state_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   index;
    logic [CH_W-1:0]    channel;
    logic               side;
    logic [IDX_W-1:0]   low;
    logic [IDX_W-1:0]   high;
    logic [STEP_W-1:0]  step;
  } cmd_t;

  // one channel result
  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [VAL_W-1:0]  agonist;
    logic signed [VAL_W-1:0]  antagonist;
    logic                     last;
  } result_t;

  // clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-VAL_W:0] top;
    top = v[SUM_W-1:VAL_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ sv/srld_front.sv @@
// ----------------------------------------------------------------------------
// srld_front
// Accepts input words, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module srld_front #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // neuron_id, channel, side, range_low, range_high, increment
  input  logic [srld_pkg::S_DATA_W-1:0]  s_tdata,
  // action
  input  logic [1:0]                     s_tuser,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output srld_pkg::cmd_t                 cmd
);

  localparam int DEPTH = 2;

  srld_pkg::cmd_t fifo [DEPTH];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  srld_pkg::cmd_t in_cmd;
  logic           keep;
  logic           push;
  logic           pop;

  // unpack and classify; unused actions and writes to absent channels drop here
  always_comb begin
    in_cmd.index   = s_tdata[15:0];
    in_cmd.channel = s_tdata[17:16];
    in_cmd.side    = s_tdata[18];
    in_cmd.low     = s_tdata[34:19];
    in_cmd.high    = s_tdata[50:35];
    in_cmd.step    = s_tdata[74:51];
    in_cmd.kind    = srld_pkg::CMD_SPIKE;
    keep           = 1'b0;
    unique case (srld_pkg::action_t'(s_tuser))
      srld_pkg::ACT_SPIKE: begin
        in_cmd.kind = srld_pkg::CMD_SPIKE;
        keep        = 1'b1;
      end
      srld_pkg::ACT_TICK: begin
        in_cmd.kind = srld_pkg::CMD_TICK;
        keep        = 1'b1;
      end
      srld_pkg::ACT_WRITE: begin
        in_cmd.kind = srld_pkg::CMD_WRITE;
        keep        = 32'(in_cmd.channel) < NUM_CHANNELS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready  = count != 2'(DEPTH);
  assign push      = s_tvalid & s_tready & keep;
  assign cmd_valid = count != 2'd0;
  assign pop       = cmd_valid & cmd_ready;
  assign cmd       = fifo[rd_ptr];

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= in_cmd;
  end

endmodule

@@ sv/srld_back.sv @@
// ----------------------------------------------------------------------------
// srld_back
// Channel state, spike and range-write execution, and the per-channel tick
// pipeline: multiply by decay, truncate toward zero, add pending, saturate.
// ----------------------------------------------------------------------------
`include "spike_range_leaky_decoder_top_macros.svh"

module srld_back #(
  parameter int NUM_CHANNELS = 4,
  parameter int INDEX_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [srld_pkg::DECAY_W-1:0]         decay,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  srld_pkg::cmd_t                       cmd,
  input  logic [srld_pkg::OUTQ_CNT_W-1:0]      out_free,
  output logic                                 push,
  output srld_pkg::result_t                    push_data
);

  localparam int IW = (INDEX_BITS < srld_pkg::IDX_W) ? INDEX_BITS : srld_pkg::IDX_W;
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VW = srld_pkg::VAL_W;
  localparam int SW = srld_pkg::SUM_W;

  // per-channel state
  logic [IW-1:0]                  ag_lo   [NUM_CHANNELS];
  logic [IW-1:0]                  ag_hi   [NUM_CHANNELS];
  logic [IW-1:0]                  an_lo   [NUM_CHANNELS];
  logic [IW-1:0]                  an_hi   [NUM_CHANNELS];
  logic [srld_pkg::STEP_W-1:0]    ag_step [NUM_CHANNELS];
  logic [srld_pkg::STEP_W-1:0]    an_step [NUM_CHANNELS];
  logic signed [VW-1:0]           ag_acc  [NUM_CHANNELS];
  logic signed [VW-1:0]           an_acc  [NUM_CHANNELS];
  logic signed [VW-1:0]           ag_pend [NUM_CHANNELS];
  logic signed [VW-1:0]           an_pend [NUM_CHANNELS];

  // spike lanes
  logic [IW-1:0]                  idx;
  logic [NUM_CHANNELS-1:0]        hit_ag;
  logic [NUM_CHANNELS-1:0]        hit_an;
  logic signed [VW-1:0]           ag_pend_sum [NUM_CHANNELS];
  logic signed [VW-1:0]           an_pend_sum [NUM_CHANNELS];

  // sequencer
  srld_pkg::back_state_t          state;
  srld_pkg::back_state_t          state_next;
  logic [CW-1:0]                  cnt;
  logic [CW-1:0]                  cnt_next;
  logic                           take;
  logic                           issue;
  logic [srld_pkg::OUTQ_CNT_W-1:0] inflight;
  logic [CW-1:0]                  wch;

  // tick pipeline
  logic                                   v1;
  logic                                   v2;
  logic signed [srld_pkg::PROD_W-1:0]     prod_ag;
  logic signed [srld_pkg::PROD_W-1:0]     prod_an;
  logic signed [VW-1:0]                   pend1_ag;
  logic signed [VW-1:0]                   pend1_an;
  logic [CW-1:0]                          ch1;
  logic                                   last1;
  logic signed [srld_pkg::PROD_W-1:0]     bias_ag;
  logic signed [srld_pkg::PROD_W-1:0]     bias_an;
  logic signed [srld_pkg::TRUNC_W-1:0]    d_ag;
  logic signed [srld_pkg::TRUNC_W-1:0]    d_an;
  logic signed [srld_pkg::TRUNC_W-1:0]    d2_ag;
  logic signed [srld_pkg::TRUNC_W-1:0]    d2_an;
  logic signed [VW-1:0]                   pend2_ag;
  logic signed [VW-1:0]                   pend2_an;
  logic [CW-1:0]                          ch2;
  logic                                   last2;

  assign idx = cmd.index[IW-1:0];
  assign wch = CW'(cmd.channel);

  // range match and saturating pending update, all channels side by side
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      hit_ag[i] = (idx >= ag_lo[i]) && (idx <= ag_hi[i]);
      hit_an[i] = (idx >= an_lo[i]) && (idx <= an_hi[i]);
      ag_pend_sum[i] = srld_pkg::sat_val(SW'(ag_pend[i]) + SW'($signed({1'b0, ag_step[i]})));
      an_pend_sum[i] = srld_pkg::sat_val(SW'(an_pend[i]) - SW'($signed({1'b0, an_step[i]})));
    end
  end

  assign inflight  = {2'b00, v1} + {2'b00, v2};
  assign cmd_ready = (state == srld_pkg::BK_IDLE) && !v1 && !v2;
  assign take      = cmd_valid & cmd_ready;

  // sequencer: one channel issued per cycle while the result queue has room
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    issue      = 1'b0;
    unique case (state)
      srld_pkg::BK_IDLE: begin
        if (take && (cmd.kind == srld_pkg::CMD_TICK)) begin
          state_next = srld_pkg::BK_ISSUE;
          cnt_next   = '0;
        end
      end
      srld_pkg::BK_ISSUE: begin
        if (inflight < out_free) begin
          issue = 1'b1;
          if (cnt == CW'(NUM_CHANNELS - 1)) begin
            state_next = srld_pkg::BK_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = srld_pkg::BK_IDLE;
      end
    endcase
  end

  // truncate toward zero: bias negative products before the shift
  always_comb begin
    bias_ag = prod_ag + (prod_ag[srld_pkg::PROD_W-1] ? 50'sd65535 : 50'sd0);
    bias_an = prod_an + (prod_an[srld_pkg::PROD_W-1] ? 50'sd65535 : 50'sd0);
    d_ag    = bias_ag[srld_pkg::PROD_W-1:16];
    d_an    = bias_an[srld_pkg::PROD_W-1:16];
  end

  // final add and clamp
  always_comb begin
    push                 = v2;
    push_data.channel    = srld_pkg::CH_W'(ch2);
    push_data.agonist    = srld_pkg::sat_val(SW'(d2_ag) + SW'(pend2_ag));
    push_data.antagonist = srld_pkg::sat_val(SW'(d2_an) + SW'(pend2_an));
    push_data.last       = last2;
  end

  // control and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srld_pkg::BK_IDLE;
      cnt   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ag_lo[i]   <= '1;
        ag_hi[i]   <= '0;
        an_lo[i]   <= '1;
        an_hi[i]   <= '0;
        ag_step[i] <= '0;
        an_step[i] <= '0;
        ag_acc[i]  <= '0;
        an_acc[i]  <= '0;
        ag_pend[i] <= '0;
        an_pend[i] <= '0;
      end
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      v1    <= issue;
      v2    <= v1;
      if (take) begin
        unique case (cmd.kind)
          srld_pkg::CMD_SPIKE: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (hit_ag[i]) ag_pend[i] <= ag_pend_sum[i];
              if (hit_an[i]) an_pend[i] <= an_pend_sum[i];
            end
          end
          srld_pkg::CMD_WRITE: begin
            if (cmd.side == srld_pkg::SIDE_AGONIST) begin
              ag_lo[wch]   <= cmd.low[IW-1:0];
              ag_hi[wch]   <= cmd.high[IW-1:0];
              ag_step[wch] <= cmd.step;
            end else begin
              an_lo[wch]   <= cmd.low[IW-1:0];
              an_hi[wch]   <= cmd.high[IW-1:0];
              an_step[wch] <= cmd.step;
            end
          end
          default: begin
          end
        endcase
      end
      // pending is captured into the pipeline and cleared as the channel issues
      if (issue) begin
        ag_pend[cnt] <= '0;
        an_pend[cnt] <= '0;
      end
      if (v2) begin
        ag_acc[ch2] <= push_data.agonist;
        an_acc[ch2] <= push_data.antagonist;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_ag  <= ag_acc[cnt] * $signed({1'b0, decay});
      prod_an  <= an_acc[cnt] * $signed({1'b0, decay});
      pend1_ag <= ag_pend[cnt];
      pend1_an <= an_pend[cnt];
      ch1      <= cnt;
      last1    <= cnt == CW'(NUM_CHANNELS - 1);
    end
    if (v1) begin
      d2_ag    <= d_ag;
      d2_an    <= d_an;
      pend2_ag <= pend1_ag;
      pend2_an <= pend1_an;
      ch2      <= ch1;
      last2    <= last1;
    end
  end

  `SRLD_ASSERT_IMPLIES(a_push_has_room, v2, out_free != '0, "result pushed into a full queue")
  `SRLD_ASSERT_IMPLIES(a_cmd_pipe_empty, cmd_ready, !v1 && !v2, "command taken during a tick")
  `SRLD_ASSERT_IMPLIES(a_last_is_top, v2 && last2, ch2 == CW'(NUM_CHANNELS - 1), "last on wrong channel")

endmodule

@@ sv/srld_outq.sv @@
// ----------------------------------------------------------------------------
// srld_outq
// Result queue driving the master stream; reports free slots as credit.
// ----------------------------------------------------------------------------
module srld_outq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  srld_pkg::result_t                   push_data,
  output logic [srld_pkg::OUTQ_CNT_W-1:0]     free,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // agonist_value, antagonist_value
  output logic [srld_pkg::M_DATA_W-1:0]       m_tdata,
  // out_channel
  output logic [srld_pkg::CH_W-1:0]           m_tuser,
  output logic                                m_tlast
);

  srld_pkg::result_t                 mem [srld_pkg::OUTQ_DEPTH];
  logic [srld_pkg::OUTQ_CNT_W-1:0]   count;
  logic [srld_pkg::OUTQ_PTR_W-1:0]   wr_ptr;
  logic [srld_pkg::OUTQ_PTR_W-1:0]   rd_ptr;
  logic                              pop;
  srld_pkg::result_t                 head;

  assign head     = mem[rd_ptr];
  assign m_tvalid = count != '0;
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = {head.antagonist, head.agonist};
  assign m_tuser  = head.channel;
  assign m_tlast  = head.last;
  assign free     = srld_pkg::OUTQ_CNT_W'(srld_pkg::OUTQ_DEPTH) - count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ sv/spike_range_leaky_decoder_top.sv @@
// ----------------------------------------------------------------------------
// spike_range_leaky_decoder_top
// Leaky-integrator spike-rate decoder with agonist and antagonist outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: tuser is the action (spike, tick, range write); tdata
//   carries the index, channel, side, range bounds and increment.
//   Master stream m_*: one word per channel on each tick, tuser the channel,
//   tlast on the highest channel. cfg_* writes the Q1.16 decay factor; the
//   user must write it only while the block is idle (the block has no check).
//   A two-word command queue sits ahead of the back end. On a tick, one
//   channel issues per cycle while the result queue has room, into a
//   multiply, truncate and saturate pipeline. Issue is paced by credit
//   from a four-word result queue, so a stalled receiver holds the
//   pipeline without loss; the command queue keeps accepting spikes until
//   it fills.
//   Reset empties every range, zeroes steps, values and pending sums, and
//   sets the decay factor to one.
// ----------------------------------------------------------------------------
module spike_range_leaky_decoder_top #(
  parameter int NUM_CHANNELS = 4,
  parameter int INDEX_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // neuron_id, channel, side, range_low, range_high, increment
  input  logic [srld_pkg::S_DATA_W-1:0]        s_tdata,
  // action
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // agonist_value, antagonist_value
  output logic [srld_pkg::M_DATA_W-1:0]        m_tdata,
  // out_channel
  output logic [srld_pkg::CH_W-1:0]            m_tuser,
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srld_pkg::DECAY_W-1:0]         cfg_data
);

  logic [srld_pkg::DECAY_W-1:0]     decay;
  logic                             cmd_valid;
  logic                             cmd_ready;
  srld_pkg::cmd_t                   cmd;
  logic [srld_pkg::OUTQ_CNT_W-1:0]  out_free;
  logic                             push;
  srld_pkg::result_t                push_data;

  // decay factor register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      decay <= srld_pkg::DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      decay <= cfg_data;
    end
  end

  srld_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  srld_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .decay     (decay),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_free  (out_free),
    .push      (push),
    .push_data (push_data)
  );

  srld_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
